// File: rtl/core/barc_pkg.sv
// Shared types and constants for the barcode bar width capture block.
// Used by barc_cell, barc_chain and barcode_bar_width_capture.
package barc_pkg;

  // Field widths
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned BAR_W   = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned MASK_W  = 29;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 2;
  // 10 * bar length needs 36 bits
  localparam int unsigned CMP_W   = 36;

  // Wide when WIDE_NUM * length > WIDE_DEN * longest (0.7 ratio)
  localparam logic [3:0] WIDE_NUM = 4'd10;
  localparam logic [3:0] WIDE_DEN = 4'd7;

  // Register reset values
  localparam logic [LEVEL_W-1:0] THRESH_RST  = 12'd1700;
  localparam logic [BAR_W-1:0]   MIN_LEN_RST = 32'd1000;
  localparam logic [BAR_W-1:0]   TIMEOUT_RST = 32'd10000000;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_BLACK_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MIN_BAR_LENGTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WHITE_TIMEOUT   = 2'd2;

  // End causes
  localparam logic CAUSE_CAPACITY = 1'b0;
  localparam logic CAUSE_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] sample_level;
    logic [TIME_W-1:0]  sample_time;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bars_found;
    logic [MASK_W-1:0]  wide_mask;
    logic [BAR_W-1:0]   longest_bar;
    logic               end_cause;
  } result_t;

  // Shift control for the bar chain
  typedef struct packed {
    logic push;  // move toward the tail, new bar enters cell 0
    logic pop;   // move toward cell 0, zero enters the tail
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PREP,
    ST_DRAIN
  } state_t;

endpackage

// File: rtl/core/barc_cell.sv
// One bar length cell of the storage chain.
// Depends on barc_pkg for widths and the chain control struct.
module barc_cell (
  input  logic                     clk,
  input  barc_pkg::chain_ctl_t     ctl,
  input  logic [barc_pkg::BAR_W-1:0] from_below,
  input  logic [barc_pkg::BAR_W-1:0] from_above,
  output logic [barc_pkg::BAR_W-1:0] value
);

  logic [barc_pkg::BAR_W-1:0] value_r;

  // Take the neighbor's length on a push or a pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value_r <= from_below;
    end else if (ctl.pop) begin
      value_r <= from_above;
    end
  end

  assign value = value_r;

endmodule

// File: rtl/core/barc_chain.sv
// Row of bar length cells: push shifts toward the tail, pop toward cell 0.
// Depends on barc_pkg and barc_cell.
module barc_chain #(
  parameter int unsigned DEPTH = 29
) (
  input  logic                       clk,
  input  barc_pkg::chain_ctl_t       ctl,
  input  logic [barc_pkg::BAR_W-1:0] push_data,
  output logic [barc_pkg::BAR_W-1:0] head
);

  logic [barc_pkg::BAR_W-1:0] cell_val [DEPTH];
  logic [barc_pkg::BAR_W-1:0] below    [DEPTH];
  logic [barc_pkg::BAR_W-1:0] above    [DEPTH];

  // Neighbor wiring; ends take the new bar and zero
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      below[i] = (i == 0) ? push_data : cell_val[(i == 0) ? 0 : i - 1];
      above[i] = (i == DEPTH - 1) ? '0 : cell_val[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    barc_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_below (below[g]),
      .from_above (above[g]),
      .value      (cell_val[g])
    );
  end

  assign head = cell_val[0];

endmodule

// File: rtl/core/barcode_bar_width_capture.sv
// Barcode bar width capture: times black/white runs, classifies bars narrow/wide.
// A finishing item gives its result after the PREP state and the DRAIN of its k bars.
// Throughput: one item per cycle while capturing; after a finish the input is
// stalled through PREP and DRAIN while the chain drains one bar a cycle.
// Sync reset (rst_n low): config registers to defaults, capture idle, no result.
// Depends on barc_pkg and barc_chain.
module barcode_bar_width_capture #(
  parameter int unsigned BAR_CAPACITY = 29
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  barc_pkg::sample_t           in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output barc_pkg::result_t           out_data,
  // configuration
  input  logic                        cfg_we,
  input  logic [barc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [barc_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(BAR_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(BAR_CAPACITY);

  // Registers
  barc_pkg::state_t                 state_r, state_nxt;
  logic [barc_pkg::LEVEL_W-1:0]     thresh_r;
  logic [barc_pkg::BAR_W-1:0]       min_len_r;
  logic [barc_pkg::BAR_W-1:0]       timeout_r;
  logic                             capturing_r, capturing_nxt;
  logic                             prev_black_r, prev_black_nxt;
  logic [barc_pkg::TIME_W-1:0]      last_edge_r, last_edge_nxt;
  logic                             white_seen_r, white_seen_nxt;
  logic [barc_pkg::TIME_W-1:0]      white_start_r, white_start_nxt;
  logic [CNT_W-1:0]                 bar_total_r, bar_total_nxt;
  logic [barc_pkg::BAR_W-1:0]       longest_r, longest_nxt;
  logic                             cause_r, cause_nxt;
  logic [CNT_W-1:0]                 drain_cnt_r, drain_cnt_nxt;
  logic [barc_pkg::MASK_W-1:0]      mask_r, mask_nxt;
  logic [barc_pkg::CMP_W-1:0]       rhs_r, rhs_nxt;
  logic                             out_valid_r, out_valid_nxt;
  barc_pkg::result_t                out_data_r, out_data_nxt;

  // Step datapath
  logic                             in_acc;
  logic                             black;
  logic                             start;
  logic                             active;
  logic                             prev_eff;
  logic [barc_pkg::TIME_W-1:0]      last_eff;
  logic                             edge_seen;
  logic [barc_pkg::TIME_W-1:0]      run_len;
  logic [barc_pkg::BAR_W-1:0]       run_sat;
  logic                             store;
  logic [CNT_W-1:0]                 total_upd;
  logic [barc_pkg::BAR_W-1:0]       longest_upd;
  logic                             cap_fin;
  logic                             ws_eff;
  logic [barc_pkg::TIME_W-1:0]      white_len;
  logic                             white_over;
  logic                             to_fin;

  // Chain and classifier
  barc_pkg::chain_ctl_t             chain_ctl;
  logic [barc_pkg::BAR_W-1:0]       chain_head;
  logic [barc_pkg::CMP_W-1:0]       lhs;
  logic                             wide_bit;
  logic                             out_free;

  assign in_stall = (state_r != barc_pkg::ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Per-sample run timing
  always_comb begin
    black     = in_data.sample_level > thresh_r;
    start     = !capturing_r && black;
    active    = capturing_r || black;
    prev_eff  = start ? 1'b1 : prev_black_r;
    last_eff  = start ? in_data.sample_time : last_edge_r;
    edge_seen = active && (black != prev_eff);
    run_len   = in_data.sample_time - last_eff;
    run_sat   = (run_len[barc_pkg::TIME_W-1:barc_pkg::BAR_W] != '0) ? '1
              : run_len[barc_pkg::BAR_W-1:0];
    store     = edge_seen && (run_len > {32'd0, min_len_r}) && (bar_total_r < CAP);
    total_upd = bar_total_r + CNT_W'(store);
    longest_upd = (store && (run_sat > longest_r)) ? run_sat : longest_r;
    cap_fin   = edge_seen && (total_upd >= CAP);
    // white timer state after capture start / capacity finish clear it
    ws_eff    = white_seen_r && !start && !cap_fin;
    white_len = in_data.sample_time - white_start_r;
    white_over = (white_len[barc_pkg::TIME_W-1:barc_pkg::BAR_W] != '0) ||
                 (white_len[barc_pkg::BAR_W-1:0] > timeout_r);
    to_fin    = active && !black && ws_eff && white_over && !cap_fin;
  end

  // Classifier on the chain head
  assign lhs      = barc_pkg::CMP_W'(chain_head) * barc_pkg::CMP_W'(barc_pkg::WIDE_NUM);
  assign wide_bit = lhs > rhs_r;

  barc_chain #(
    .DEPTH (BAR_CAPACITY)
  ) u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .push_data (run_sat),
    .head      (chain_head)
  );

  // Next state and datapath
  always_comb begin
    state_nxt       = state_r;
    capturing_nxt   = capturing_r;
    prev_black_nxt  = prev_black_r;
    last_edge_nxt   = last_edge_r;
    white_seen_nxt  = white_seen_r;
    white_start_nxt = white_start_r;
    bar_total_nxt   = bar_total_r;
    longest_nxt     = longest_r;
    cause_nxt       = cause_r;
    drain_cnt_nxt   = drain_cnt_r;
    mask_nxt        = mask_r;
    rhs_nxt         = rhs_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    chain_ctl       = '0;

    unique case (state_r)
      barc_pkg::ST_RUN: begin
        if (in_acc) begin
          if (!active) begin
            white_seen_nxt = 1'b0;
          end else begin
            capturing_nxt = 1'b1;
            if (start) begin
              prev_black_nxt = 1'b1;
              last_edge_nxt  = in_data.sample_time;
            end
            if (edge_seen) begin
              prev_black_nxt = black;
              last_edge_nxt  = in_data.sample_time;
              bar_total_nxt  = total_upd;
              longest_nxt    = longest_upd;
              chain_ctl.push = store;
            end
            // white timer
            if (!black) begin
              if (!ws_eff) begin
                white_seen_nxt  = 1'b1;
                white_start_nxt = in_data.sample_time;
              end else if (white_over) begin
                white_seen_nxt = 1'b0;
              end
            end else begin
              white_seen_nxt = 1'b0;
            end
            if (cap_fin || to_fin) begin
              capturing_nxt = 1'b0;
              cause_nxt     = to_fin ? barc_pkg::CAUSE_TIMEOUT : barc_pkg::CAUSE_CAPACITY;
              state_nxt     = barc_pkg::ST_PREP;
            end
          end
        end
      end

      barc_pkg::ST_PREP: begin
        rhs_nxt       = barc_pkg::CMP_W'(longest_r) * barc_pkg::CMP_W'(barc_pkg::WIDE_DEN);
        drain_cnt_nxt = '0;
        mask_nxt      = '0;
        state_nxt     = barc_pkg::ST_DRAIN;
      end

      barc_pkg::ST_DRAIN: begin
        // newest bar comes out first; LSB insertion puts bar i at bit i
        if (drain_cnt_r != bar_total_r) begin
          chain_ctl.pop = 1'b1;
          mask_nxt      = {mask_r[barc_pkg::MASK_W-2:0], wide_bit};
          drain_cnt_nxt = drain_cnt_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.bars_found  = barc_pkg::COUNT_W'(bar_total_r);
          out_data_nxt.wide_mask   = mask_r;
          out_data_nxt.longest_bar = longest_r;
          out_data_nxt.end_cause   = cause_r;
          bar_total_nxt            = '0;
          longest_nxt              = '0;
          white_seen_nxt           = white_seen_r;
          state_nxt                = barc_pkg::ST_RUN;
        end
      end

      default: begin
        state_nxt = barc_pkg::ST_RUN;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= barc_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r  <= 1'b0;
      prev_black_r <= 1'b0;
      white_seen_r <= 1'b0;
      bar_total_r  <= '0;
      longest_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      capturing_r  <= capturing_nxt;
      prev_black_r <= prev_black_nxt;
      white_seen_r <= white_seen_nxt;
      bar_total_r  <= bar_total_nxt;
      longest_r    <= longest_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_edge_r   <= last_edge_nxt;
    white_start_r <= white_start_nxt;
    cause_r       <= cause_nxt;
    drain_cnt_r   <= drain_cnt_nxt;
    mask_r        <= mask_nxt;
    rhs_r         <= rhs_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= barc_pkg::THRESH_RST;
      min_len_r <= barc_pkg::MIN_LEN_RST;
      timeout_r <= barc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        barc_pkg::CFG_BLACK_THRESHOLD: thresh_r  <= cfg_wdata[barc_pkg::LEVEL_W-1:0];
        barc_pkg::CFG_MIN_BAR_LENGTH:  min_len_r <= cfg_wdata;
        barc_pkg::CFG_WHITE_TIMEOUT:   timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Drain never walks past the stored bars
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == barc_pkg::ST_DRAIN |-> drain_cnt_r <= bar_total_r)
    else $error("drain count beyond bar total");

  // A capture in progress always has room left
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == barc_pkg::ST_RUN && capturing_r) |-> bar_total_r < CAP)
    else $error("capture at capacity without finishing");

  // Idle block holds no bars
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == barc_pkg::ST_RUN && !capturing_r) |-> (bar_total_r == '0 && longest_r == '0))
    else $error("bars left over outside a capture");

  // A new result only comes from a completed drain
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == barc_pkg::ST_DRAIN)
    else $error("result without drain");
`endif

endmodule
